@@ rtl/jnv_pkg.sv @@
// ----------------------------------------------------------------------------
// jnv_pkg
// Shared types and constants for the JSON number validator: grammar state
// codes, verdict codes and the character codes that the grammar names.
// ----------------------------------------------------------------------------
package jnv_pkg;

   localparam int STATE_W = 4;
   localparam int ERR_W   = 2;

   localparam logic [STATE_W-1:0] STATE_START = 4'd0;
   localparam logic [STATE_W-1:0] STATE_MINUS = 4'd1;
   localparam logic [STATE_W-1:0] STATE_ZERO  = 4'd2;
   localparam logic [STATE_W-1:0] STATE_INT   = 4'd3;
   localparam logic [STATE_W-1:0] STATE_DOT   = 4'd4;
   localparam logic [STATE_W-1:0] STATE_FRAC  = 4'd5;
   localparam logic [STATE_W-1:0] STATE_EXP   = 4'd6;
   localparam logic [STATE_W-1:0] STATE_ESIGN = 4'd7;
   localparam logic [STATE_W-1:0] STATE_EDIG  = 4'd8;
   localparam logic [STATE_W-1:0] STATE_ERR   = 4'd9;

   localparam logic [ERR_W-1:0] VERDICT_OK   = 2'd0;
   localparam logic [ERR_W-1:0] VERDICT_FRAC = 2'd1;
   localparam logic [ERR_W-1:0] VERDICT_EXP  = 2'd2;
   localparam logic [ERR_W-1:0] VERDICT_OTH  = 2'd3;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_E = 8'h65;
   localparam logic [7:0] CHAR_UP_E  = 8'h45;

   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [ERR_W-1:0]   err;
      logic [ERR_W-1:0]   verdict;
   } step_result_type;

endpackage

@@ rtl/jnv_if.sv @@
// ----------------------------------------------------------------------------
// jnv_req_if / jnv_rsp_if
// Valid/ready channels that carry one character in and one verdict out.
// ----------------------------------------------------------------------------
interface jnv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       is_final;

   modport source (output valid, output char_byte, output is_final, input ready);
   modport sink   (input valid, input char_byte, input is_final, output ready);
endinterface

interface jnv_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;
   logic       is_valid;

   modport source (output valid, output verdict, output is_valid, input ready);
   modport sink   (input valid, input verdict, input is_valid, output ready);
endinterface

@@ rtl/jnv_step.sv @@
// ----------------------------------------------------------------------------
// jnv_step
// Grammar transition for one character and the verdict that the token
// would get if it ended on that character.
// ----------------------------------------------------------------------------
module jnv_step (
   input  logic [jnv_pkg::STATE_W-1:0] cur_state,
   input  logic [jnv_pkg::ERR_W-1:0]   cur_err,
   input  logic [7:0]                  char_byte,
   output jnv_pkg::step_result_type    result
);

   logic is_dig;
   logic is_nz;
   logic is_e;
   logic is_sign;
   logic [jnv_pkg::STATE_W-1:0] nxt_state;
   logic [jnv_pkg::ERR_W-1:0]   nxt_err;
   logic [jnv_pkg::ERR_W-1:0]   verdict;

   assign is_dig  = (char_byte >= jnv_pkg::CHAR_ZERO) && (char_byte <= jnv_pkg::CHAR_NINE);
   assign is_nz   = (char_byte >= jnv_pkg::CHAR_ONE) && (char_byte <= jnv_pkg::CHAR_NINE);
   assign is_e    = (char_byte == jnv_pkg::CHAR_LOW_E) || (char_byte == jnv_pkg::CHAR_UP_E);
   assign is_sign = (char_byte == jnv_pkg::CHAR_PLUS) || (char_byte == jnv_pkg::CHAR_MINUS);

   always_comb begin
      nxt_state = jnv_pkg::STATE_ERR;
      nxt_err   = jnv_pkg::VERDICT_OTH;
      case (cur_state)
         jnv_pkg::STATE_START: begin
            if (char_byte == jnv_pkg::CHAR_MINUS) nxt_state = jnv_pkg::STATE_MINUS;
            else if (char_byte == jnv_pkg::CHAR_ZERO) nxt_state = jnv_pkg::STATE_ZERO;
            else if (is_nz) nxt_state = jnv_pkg::STATE_INT;
         end
         jnv_pkg::STATE_MINUS: begin
            if (char_byte == jnv_pkg::CHAR_ZERO) nxt_state = jnv_pkg::STATE_ZERO;
            else if (is_nz) nxt_state = jnv_pkg::STATE_INT;
         end
         jnv_pkg::STATE_ZERO: begin
            if (char_byte == jnv_pkg::CHAR_DOT) nxt_state = jnv_pkg::STATE_DOT;
            else if (is_e) nxt_state = jnv_pkg::STATE_EXP;
         end
         jnv_pkg::STATE_INT: begin
            if (is_dig) nxt_state = jnv_pkg::STATE_INT;
            else if (char_byte == jnv_pkg::CHAR_DOT) nxt_state = jnv_pkg::STATE_DOT;
            else if (is_e) nxt_state = jnv_pkg::STATE_EXP;
         end
         jnv_pkg::STATE_DOT: begin
            if (is_dig) nxt_state = jnv_pkg::STATE_FRAC;
            else nxt_err = jnv_pkg::VERDICT_FRAC;
         end
         jnv_pkg::STATE_FRAC: begin
            if (is_dig) nxt_state = jnv_pkg::STATE_FRAC;
            else if (is_e) nxt_state = jnv_pkg::STATE_EXP;
         end
         jnv_pkg::STATE_EXP: begin
            if (is_sign) nxt_state = jnv_pkg::STATE_ESIGN;
            else if (is_dig) nxt_state = jnv_pkg::STATE_EDIG;
            else nxt_err = jnv_pkg::VERDICT_EXP;
         end
         jnv_pkg::STATE_ESIGN: begin
            if (is_dig) nxt_state = jnv_pkg::STATE_EDIG;
            else nxt_err = jnv_pkg::VERDICT_EXP;
         end
         jnv_pkg::STATE_EDIG: begin
            if (is_dig) nxt_state = jnv_pkg::STATE_EDIG;
         end
         jnv_pkg::STATE_ERR: begin
            nxt_err = cur_err;
         end
         default: begin
            nxt_state = jnv_pkg::STATE_ERR;
         end
      endcase
      if (nxt_state != jnv_pkg::STATE_ERR) begin
         nxt_err = jnv_pkg::VERDICT_OK;
      end
   end

   always_comb begin
      case (nxt_state)
         jnv_pkg::STATE_ZERO,
         jnv_pkg::STATE_INT,
         jnv_pkg::STATE_FRAC,
         jnv_pkg::STATE_EDIG:  verdict = jnv_pkg::VERDICT_OK;
         jnv_pkg::STATE_DOT:   verdict = jnv_pkg::VERDICT_FRAC;
         jnv_pkg::STATE_EXP,
         jnv_pkg::STATE_ESIGN: verdict = jnv_pkg::VERDICT_EXP;
         jnv_pkg::STATE_ERR: begin
            verdict = (nxt_err == jnv_pkg::VERDICT_OK) ? jnv_pkg::VERDICT_OTH : nxt_err;
         end
         default:              verdict = jnv_pkg::VERDICT_OTH;
      endcase
   end

   assign result.state   = nxt_state;
   assign result.err     = nxt_err;
   assign result.verdict = verdict;

endmodule

@@ rtl/json_number_validator.sv @@
// ----------------------------------------------------------------------------
// json_number_validator
// Checks a number token, one character per word, against the JSON number
// grammar and gives one verdict word on the token's final character.
// ----------------------------------------------------------------------------
// Each character word is captured in an input register, stepped through the
// grammar combinationally, and, if it is the final one, its verdict lands in a
// result register. One character is taken every cycle, and the input keeps
// flowing while a verdict waits, until a second final character would need
// the result slot and stalls in the input register.
module json_number_validator (
   input logic            clock,
   input logic            reset,
   jnv_req_if.sink        req_chan,
   jnv_rsp_if.source      rsp_chan
);

   logic                        in_valid_ff;
   logic [7:0]                  in_char_ff;
   logic                        in_final_ff;
   logic [jnv_pkg::STATE_W-1:0] state_ff;
   logic [jnv_pkg::STATE_W-1:0] state_in;
   logic [jnv_pkg::ERR_W-1:0]   err_ff;
   logic [jnv_pkg::ERR_W-1:0]   err_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [jnv_pkg::ERR_W-1:0]   verdict_ff;

   logic                     out_free;
   logic                     step_fire;
   logic                     req_take;
   jnv_pkg::step_result_type step_res;

   jnv_step u_step (
      .cur_state (state_ff),
      .cur_err   (err_ff),
      .char_byte (in_char_ff),
      .result    (step_res)
   );

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign step_fire = in_valid_ff && (!in_final_ff || out_free);
   assign req_chan.ready = !in_valid_ff || step_fire;
   assign req_take  = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (step_fire) begin
         if (in_final_ff) begin
            state_in     = jnv_pkg::STATE_START;
            err_in       = jnv_pkg::VERDICT_OK;
            rsp_valid_in = 1'b1;
         end else begin
            state_in = step_res.state;
            err_in   = step_res.err;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= jnv_pkg::STATE_START;
         err_ff       <= jnv_pkg::VERDICT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         state_ff     <= state_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff  <= req_chan.char_byte;
         in_final_ff <= req_chan.is_final;
      end
      if (step_fire && in_final_ff) begin
         verdict_ff <= step_res.verdict;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.verdict  = verdict_ff;
   assign rsp_chan.is_valid = (verdict_ff == jnv_pkg::VERDICT_OK);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff && (state_ff == jnv_pkg::STATE_START))
      else $error("reset did not clear the control state");

   a_err_has_code: assert property (@(posedge clock) disable iff (reset)
      (state_ff == jnv_pkg::STATE_ERR) |-> (err_ff != jnv_pkg::VERDICT_OK))
      else $error("error state without a recorded error code");

   a_final_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_final_ff) |=> rsp_valid_ff)
      else $error("final character did not produce a verdict");

   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      (step_fire && in_final_ff) |=>
         (state_ff == jnv_pkg::STATE_START) && (err_ff == jnv_pkg::VERDICT_OK))
      else $error("grammar did not restart after a final character");

   a_no_step_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_final_ff && rsp_valid_ff && !rsp_chan.ready) |=> in_valid_ff)
      else $error("final character left the input register while the result was full");

endmodule
